/* hdl/awa_pkg.sv */
// shared types, opcodes and GF(2^8) helper for the AES word ALU
// no dependencies; imported by the interfaces and all modules
package awa_pkg;

  localparam int LANES  = 4;
  localparam int BYTE_W = 8;
  localparam int WORD_W = LANES * BYTE_W;
  localparam int OP_W   = 3;

  localparam logic [BYTE_W-1:0] GF_REDUCE = 8'h1B;

  typedef enum logic [OP_W-1:0] {
    OP_XOR    = 3'd0,
    OP_MUL    = 3'd1,
    OP_ROT_DN = 3'd2,
    OP_ROT_UP = 3'd3,
    OP_CMP    = 3'd4
  } opcode_t;

  typedef logic [LANES-1:0][BYTE_W-1:0] word_bytes_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_result;
    logic              less_than;
    logic              equal;
  } result_t;

  // product modulo x^8+x^4+x^3+x+1
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] x,
                                               input logic [BYTE_W-1:0] y);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] xs;
    acc = '0;
    xs  = x;
    for (int k = 0; k < BYTE_W; k++) begin
      if (y[k]) acc = acc ^ xs;
      xs = {xs[BYTE_W-2:0], 1'b0} ^ (xs[BYTE_W-1] ? GF_REDUCE : '0);
    end
    return acc;
  endfunction

endpackage

/* hdl/awa_if.sv */
// valid/ready channel interfaces for operand and result words
// depends on awa_pkg
interface awa_in_if
  import awa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [WORD_W-1:0] operand_a;
  logic [WORD_W-1:0] operand_b;

  modport source (output valid, opcode, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface awa_out_if
  import awa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_result;
  logic              less_than;
  logic              equal;

  modport source (output valid, word_result, less_than, equal, input ready);
  modport sink   (input valid, word_result, less_than, equal, output ready);
endinterface

/* hdl/awa_lane.sv */
// one byte lane: xor, GF(2^8) word-multiply term sum and byte rotates
// depends on awa_pkg; a_sel[j] carries operand_a byte (lane - j) mod 4
module awa_lane
  import awa_pkg::*;
(
  input  logic [OP_W-1:0]   opcode,
  input  word_bytes_t       a_sel,
  input  word_bytes_t       b_bytes,
  input  logic [BYTE_W-1:0] b_own,
  output logic [BYTE_W-1:0] lane_byte
);

  logic [BYTE_W-1:0] prod_sum;

  always_comb begin
    prod_sum = '0;
    for (int j = 0; j < LANES; j++) begin
      prod_sum = prod_sum ^ gf_mul(a_sel[j], b_bytes[j]);
    end
  end

  always_comb begin
    unique case (opcode_t'(opcode))
      OP_XOR:    lane_byte = a_sel[0] ^ b_own;
      OP_MUL:    lane_byte = prod_sum;
      OP_ROT_DN: lane_byte = a_sel[LANES-1];
      OP_ROT_UP: lane_byte = a_sel[1];
      default:   lane_byte = '0;
    endcase
  end

endmodule

/* hdl/awa_merge.sv */
// merge stage: joins lane bytes, runs the compare and holds the result register
// depends on awa_pkg and awa_out_if
module awa_merge
  import awa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [OP_W-1:0]   opcode,
  input  logic [WORD_W-1:0] operand_a,
  input  logic [WORD_W-1:0] operand_b,
  input  word_bytes_t       lane_bytes,
  output logic              take_ready,
  awa_out_if.source         out_word
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    is_cmp;

  assign take_ready = !valid_r || out_word.ready;
  assign is_cmp     = (opcode_t'(opcode) == OP_CMP);

  always_comb begin
    res_nxt.word_result = is_cmp ? '0 : WORD_W'(lane_bytes);
    res_nxt.less_than   = is_cmp && (operand_a < operand_b);
    res_nxt.equal       = is_cmp && (operand_a == operand_b);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take_ready) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && take_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_word.valid       = valid_r;
  assign out_word.word_result = res_r.word_result;
  assign out_word.less_than   = res_r.less_than;
  assign out_word.equal       = res_r.equal;

endmodule

/* hdl/aes_word_alu.sv */
// AES word ALU top level: four byte lanes feeding one registered merge stage
// depends on awa_pkg, awa_if, awa_lane and awa_merge
//
// Takes one operand word pair per cycle and returns its result in the next
// cycle; full throughput is one word per clock while the sink keeps taking
// words. The four byte lanes and the compare are combinational ahead of a
// single output register, and the input stalls only while that register holds
// a word the sink has not taken. Opcodes 5 to 7 return an all-zero result.
module aes_word_alu
  import awa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  awa_in_if.sink    in_word,
  awa_out_if.source out_word
);

  word_bytes_t a_bytes;
  word_bytes_t b_bytes;
  word_bytes_t lane_bytes;
  word_bytes_t a_sel [LANES];
  logic        take_ready;

  assign a_bytes = in_word.operand_a;
  assign b_bytes = in_word.operand_b;

  genvar gi, gj;
  generate
    for (gi = 0; gi < LANES; gi++) begin : g_lane
      for (gj = 0; gj < LANES; gj++) begin : g_sel
        assign a_sel[gi][gj] = a_bytes[(gi - gj + LANES) % LANES];
      end

      awa_lane u_lane (
        .opcode    (in_word.opcode),
        .a_sel     (a_sel[gi]),
        .b_bytes   (b_bytes),
        .b_own     (b_bytes[gi]),
        .lane_byte (lane_bytes[gi])
      );
    end
  endgenerate

  awa_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_word.valid),
    .opcode     (in_word.opcode),
    .operand_a  (in_word.operand_a),
    .operand_b  (in_word.operand_b),
    .lane_bytes (lane_bytes),
    .take_ready (take_ready),
    .out_word   (out_word)
  );

  assign in_word.ready = take_ready;

endmodule

/* bench/aes_word_alu_test.sv */
// self-checking bench for aes_word_alu: directed and random operand words,
// results predicted in the bench and compared field by field
// depends on awa_pkg, awa_if and the aes_word_alu rtl
`timescale 1ns / 1ps

module aes_word_alu_test;
  import awa_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0]   OP_SPARE_LAST  = 3'd7;
  localparam logic [BYTE_W-1:0] AES_POLY_LOW   = 8'h1B;
  localparam int IDLE_PCT    = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  bit   steady_run;
  int   error_count;

  result_t predicted_q[$];

  awa_in_if  in_ch();
  awa_out_if out_ch();

  aes_word_alu uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  always #10 clk = ~clk;

  function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] x,
                                                   input logic [BYTE_W-1:0] y);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] shifted;
    acc = '0;
    shifted = x;
    for (int k = 0; k < BYTE_W; k++) begin
      if (y[k]) acc = acc ^ shifted;
      if (shifted[BYTE_W-1]) shifted = (shifted << 1) ^ AES_POLY_LOW;
      else shifted = shifted << 1;
    end
    return acc;
  endfunction

  function automatic logic [WORD_W-1:0] word_product(input word_bytes_t a,
                                                     input word_bytes_t b);
    word_bytes_t r;
    for (int i = 0; i < LANES; i++) begin
      r[i] = '0;
      for (int j = 0; j < LANES; j++) begin
        r[i] = r[i] ^ gf_product(a[(i - j + LANES) % LANES], b[j]);
      end
    end
    return r;
  endfunction

  function automatic result_t alu_outcome(input logic [OP_W-1:0] op,
                                          input logic [WORD_W-1:0] a,
                                          input logic [WORD_W-1:0] b);
    result_t r;
    r = '0;
    case (op)
      OP_XOR:    r.word_result = a ^ b;
      OP_MUL:    r.word_result = word_product(a, b);
      OP_ROT_DN: r.word_result = {a[BYTE_W-1:0], a[WORD_W-1:BYTE_W]};
      OP_ROT_UP: r.word_result = {a[WORD_W-BYTE_W-1:0], a[WORD_W-1:WORD_W-BYTE_W]};
      OP_CMP: begin
        r.less_than = (a < b);
        r.equal     = (a == b);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready)
        predicted_q.insert(predicted_q.size(),
                           alu_outcome(in_ch.opcode, in_ch.operand_a, in_ch.operand_b));
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_q.size() == 0) begin
          $display("%0t: unexpected result word: expected none, got %h lt %b eq %b",
                   $time, out_ch.word_result, out_ch.less_than, out_ch.equal);
          error_count++;
        end else begin
          want = predicted_q.pop_front();
          if (out_ch.word_result !== want.word_result) begin
            $display("%0t: word_result mismatch: expected %h, got %h",
                     $time, want.word_result, out_ch.word_result);
            error_count++;
          end
          if (out_ch.less_than !== want.less_than) begin
            $display("%0t: less_than mismatch: expected %b, got %b",
                     $time, want.less_than, out_ch.less_than);
            error_count++;
          end
          if (out_ch.equal !== want.equal) begin
            $display("%0t: equal mismatch: expected %b, got %b",
                     $time, want.equal, out_ch.equal);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("aes_word_alu_test: done, errors");
    $finish;
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b);
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_results;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (predicted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_operand;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(WORD_W - 1);
      3: return ~(32'h1 << $urandom_range(WORD_W - 1));
      4: return {LANES{8'($urandom)}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode;
    int roll;
    roll = $urandom_range(99);
    if (roll < 18) return OP_XOR;
    if (roll < 42) return OP_MUL;
    if (roll < 56) return OP_ROT_DN;
    if (roll < 70) return OP_ROT_UP;
    if (roll < 94) return OP_CMP;
    return OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
  endfunction

  task automatic send_random_word;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    op = pick_opcode();
    a  = pick_operand();
    b  = pick_operand();
    if (op == OP_CMP) begin
      case ($urandom_range(9))
        0, 1, 2: b = a;
        3, 4: begin
          b = a;
          b[8 * $urandom_range(LANES - 1) +: BYTE_W] = 8'($urandom);
        end
        5: b = a ^ (32'h1 << $urandom_range(WORD_W - 1));
        default: ;
      endcase
    end
    send_word(op, a, b);
  endtask

  task automatic test_xor_extremes;
    send_word(OP_XOR, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_XOR, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_XOR, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
  endtask

  task automatic test_multiply_cases;
    send_word(OP_MUL, 32'h0102_0304, 32'h0000_0001);
    send_word(OP_MUL, 32'hDB13_5345, 32'h0301_0102);
    send_word(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_MUL, 32'h8080_8080, 32'h0202_0202);
    send_word(OP_MUL, 32'h0000_0000, 32'hFFFF_FFFF);
  endtask

  task automatic test_rotate_cases;
    send_word(OP_ROT_DN, 32'h0123_4567, 32'hFFFF_FFFF);
    send_word(OP_ROT_UP, 32'h0123_4567, 32'h0000_0000);
    send_word(OP_ROT_DN, 32'h8000_0001, 32'h0000_0000);
    send_word(OP_ROT_UP, 32'h8000_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_compare_cases;
    send_word(OP_CMP, 32'h1234_5678, 32'h1234_5678);
    send_word(OP_CMP, 32'h00FF_FFFF, 32'h0100_0000);
    send_word(OP_CMP, 32'h1234_5679, 32'h1234_5678);
    send_word(OP_CMP, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_CMP, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_unused_opcodes;
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_word(op[OP_W-1:0], $urandom, $urandom);
  endtask

  task automatic test_drain_pause;
    repeat (10) send_random_word();
    wait_for_results();
    repeat (10) send_random_word();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_word();
  endtask

  task automatic test_back_to_back(input int count);
    steady_run = 1'b1;
    repeat (count) send_random_word();
    steady_run = 1'b0;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.opcode    = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    steady_run      = 1'b0;
    error_count     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_xor_extremes();
    test_multiply_cases();
    test_rotate_cases();
    test_compare_cases();
    test_unused_opcodes();
    test_drain_pause();
    test_random_mix(500);
    test_back_to_back(150);
    test_random_mix(460);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_q.size() != 0) begin
      $display("%0t: results missing: expected %0d more, got none",
               $time, predicted_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("aes_word_alu_test: done, clean");
    end else begin
      $display("aes_word_alu_test: done, errors");
    end
    $finish;
  end

endmodule

/* aes_word_alu.f */
hdl/awa_pkg.sv
hdl/awa_if.sv
hdl/awa_lane.sv
hdl/awa_merge.sv
hdl/aes_word_alu.sv
bench/aes_word_alu_test.sv
